/* rtl/core/ssi_pkg.sv */
// ----------------------------------------------------------------------------
// ssi_pkg
// shared types and constants of the stick setpoint integrator
// ----------------------------------------------------------------------------
package ssi_pkg;

  // setpoint accumulator width
  localparam int unsigned SP_W = 32;

  // port widths
  localparam int unsigned IN_DATA_W  = 168;
  localparam int unsigned OUT_DATA_W = 136;
  localparam int unsigned CFG_IDX_W  = 8;
  localparam int unsigned CFG_DATA_W = 8;

  // queue between front and back
  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QPTR_W = 1;
  localparam int unsigned QCNT_W = 2;

  // arithmetic constants
  localparam logic signed [7:0]  DEADBAND    = 8'sd10;
  localparam logic signed [31:0] ATT_COEF    = 32'sd1430;
  localparam logic signed [11:0] CLIMB_STEP  = 12'sd1270;
  localparam logic signed [15:0] YAW_COEF    = 16'sd50;
  localparam int unsigned        CLIMB_SHIFT = 6;
  localparam int unsigned        SPEED_SHIFT = 3;

  // input item kinds
  localparam logic KIND_TICK = 1'b0;
  localparam logic KIND_LOAD = 1'b1;

  // command codes
  localparam logic [1:0] CMD_ATT   = 2'd2;
  localparam logic [1:0] CMD_HOVER = 2'd3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_HOVER_MODE = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_VEHICLE_ID = 8'd1;

  // classified operation handed from front to back
  typedef struct packed {
    logic              kind;
    logic signed [7:0]  d_alt;
    logic signed [15:0] d_head;
    logic signed [7:0]  d_lon;
    logic signed [7:0]  d_lat;
    logic [31:0]        att_first;
    logic [31:0]        att_second;
    logic [31:0]        ld_lon;
    logic [31:0]        ld_lat;
    logic [31:0]        ld_alt;
    logic [31:0]        ld_heading;
  } op_t;

  // configuration seen by the back end
  typedef struct packed {
    logic       hover;
    logic [7:0] vehicle;
  } cfg_t;

  // one command result
  typedef struct packed {
    logic [1:0]  code;
    logic [31:0] alt;
    logic [31:0] first;
    logic [31:0] second;
    logic [31:0] heading;
    logic [7:0]  vehicle;
  } res_t;

endpackage

/* rtl/core/ssi_queue.sv */
// ----------------------------------------------------------------------------
// ssi_queue
// two-entry fifo decoupling the classifier from the integrator
// ----------------------------------------------------------------------------
module ssi_queue (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         wr_en,
  input  ssi_pkg::op_t wr_data,
  output logic         full,
  input  logic         rd_en,
  output ssi_pkg::op_t rd_data,
  output logic         empty
);

  ssi_pkg::op_t                   mem_r [ssi_pkg::QDEPTH];
  logic [ssi_pkg::QPTR_W-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [ssi_pkg::QPTR_W-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [ssi_pkg::QCNT_W-1:0]     count_r, count_nxt;

  assign full    = (count_r == ssi_pkg::QCNT_W'(ssi_pkg::QDEPTH));
  assign empty   = (count_r == '0);
  assign rd_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (wr_en) begin
      wr_ptr_nxt = wr_ptr_r + 1'b1;
    end
    if (rd_en) begin
      rd_ptr_nxt = rd_ptr_r + 1'b1;
    end
    if (wr_en && !rd_en) begin
      count_nxt = count_r + 1'b1;
    end else if (rd_en && !wr_en) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

/* rtl/core/ssi_front.sv */
// ----------------------------------------------------------------------------
// ssi_front
// accepts input transactions, applies deadband and button edges
// ----------------------------------------------------------------------------
module ssi_front (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [ssi_pkg::IN_DATA_W-1:0]  in_tdata,
  input  logic                           in_tuser,
  input  logic                           q_full,
  output logic                           q_wr,
  output ssi_pkg::op_t                   q_wdata
);

  function automatic logic signed [7:0] deadband(input logic signed [7:0] v);
    return (v >= ssi_pkg::DEADBAND || v <= -ssi_pkg::DEADBAND) ? v : 8'sd0;
  endfunction

  logic              prev_up_r, prev_up_nxt;
  logic              prev_down_r, prev_down_nxt;
  logic signed [7:0]  roll_db, pitch_db, yaw_db, climb_db;
  logic signed [11:0] climb;
  logic              up, down;
  logic              accept;

  assign in_tready = !q_full;
  assign accept    = in_tvalid && !q_full;
  assign q_wr      = accept;

  assign roll_db  = deadband(in_tdata[7:0]);
  assign pitch_db = deadband(in_tdata[15:8]);
  assign yaw_db   = deadband(in_tdata[23:16]);
  assign climb_db = deadband(in_tdata[31:24]);
  assign up       = in_tdata[32];
  assign down     = in_tdata[33];

  always_comb begin
    climb = 12'(climb_db);
    // down edge wins over up edge
    if (up && !prev_up_r) begin
      climb = -ssi_pkg::CLIMB_STEP;
    end
    if (down && !prev_down_r) begin
      climb = ssi_pkg::CLIMB_STEP;
    end

    q_wdata.kind       = in_tuser;
    q_wdata.d_alt      = 8'(climb >>> ssi_pkg::CLIMB_SHIFT);
    q_wdata.d_head     = 16'(yaw_db) * ssi_pkg::YAW_COEF;
    q_wdata.d_lon      = roll_db >>> ssi_pkg::SPEED_SHIFT;
    q_wdata.d_lat      = 8'(-(pitch_db >>> ssi_pkg::SPEED_SHIFT));
    q_wdata.att_first  = 32'(32'(roll_db) * ssi_pkg::ATT_COEF);
    q_wdata.att_second = 32'(32'(pitch_db) * ssi_pkg::ATT_COEF);
    q_wdata.ld_lon     = in_tdata[65:34];
    q_wdata.ld_lat     = in_tdata[97:66];
    q_wdata.ld_alt     = in_tdata[129:98];
    q_wdata.ld_heading = in_tdata[161:130];

    prev_up_nxt   = prev_up_r;
    prev_down_nxt = prev_down_r;
    if (accept && in_tuser == ssi_pkg::KIND_TICK) begin
      prev_up_nxt   = up;
      prev_down_nxt = down;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_up_r   <= 1'b0;
      prev_down_r <= 1'b0;
    end else begin
      prev_up_r   <= prev_up_nxt;
      prev_down_r <= prev_down_nxt;
    end
  end

endmodule

/* rtl/core/ssi_back.sv */
// ----------------------------------------------------------------------------
// ssi_back
// setpoint accumulators and command output register
// ----------------------------------------------------------------------------
module ssi_back (
  input  logic          clk,
  input  logic          rst_n,
  input  ssi_pkg::cfg_t cfg,
  input  logic          q_empty,
  input  ssi_pkg::op_t  q_rdata,
  output logic          q_rd,
  output logic          out_tvalid,
  input  logic          out_tready,
  output ssi_pkg::res_t res
);

  logic [ssi_pkg::SP_W-1:0] lon_r, lon_nxt;
  logic [ssi_pkg::SP_W-1:0] lat_r, lat_nxt;
  logic [ssi_pkg::SP_W-1:0] alt_r, alt_nxt;
  logic [ssi_pkg::SP_W-1:0] head_r, head_nxt;
  logic                     plan_r, plan_nxt;
  logic                     out_valid_r, out_valid_nxt;
  ssi_pkg::res_t            res_r, res_nxt;
  logic                     emit;

  assign q_rd       = !q_empty && (!out_valid_r || out_tready);
  assign emit       = q_rd && q_rdata.kind == ssi_pkg::KIND_TICK && plan_r;
  assign out_tvalid = out_valid_r;
  assign res        = res_r;

  always_comb begin
    lon_nxt  = lon_r;
    lat_nxt  = lat_r;
    alt_nxt  = alt_r;
    head_nxt = head_r;
    plan_nxt = plan_r;
    res_nxt  = res_r;

    if (q_rd && q_rdata.kind == ssi_pkg::KIND_LOAD) begin
      lon_nxt  = ssi_pkg::SP_W'($signed(q_rdata.ld_lon));
      lat_nxt  = ssi_pkg::SP_W'($signed(q_rdata.ld_lat));
      alt_nxt  = ssi_pkg::SP_W'($signed(q_rdata.ld_alt));
      head_nxt = ssi_pkg::SP_W'($signed(q_rdata.ld_heading));
      plan_nxt = 1'b1;
    end

    if (emit) begin
      alt_nxt  = alt_r + ssi_pkg::SP_W'(q_rdata.d_alt);
      head_nxt = head_r + ssi_pkg::SP_W'(q_rdata.d_head);
      if (cfg.hover) begin
        lon_nxt = lon_r + ssi_pkg::SP_W'(q_rdata.d_lon);
        lat_nxt = lat_r + ssi_pkg::SP_W'(q_rdata.d_lat);
      end
      res_nxt.code    = cfg.hover ? ssi_pkg::CMD_HOVER : ssi_pkg::CMD_ATT;
      res_nxt.alt     = 32'(alt_nxt);
      res_nxt.first   = cfg.hover ? 32'(lat_nxt) : q_rdata.att_first;
      res_nxt.second  = cfg.hover ? 32'(lon_nxt) : q_rdata.att_second;
      res_nxt.heading = 32'(head_nxt);
      res_nxt.vehicle = cfg.vehicle;
    end

    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lon_r       <= '0;
      lat_r       <= '0;
      alt_r       <= '0;
      head_r      <= '0;
      plan_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      lon_r       <= lon_nxt;
      lat_r       <= lat_nxt;
      alt_r       <= alt_nxt;
      head_r      <= head_nxt;
      plan_r      <= plan_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

endmodule

/* rtl/core/stick_setpoint_integrator_core.sv */
// ----------------------------------------------------------------------------
// stick_setpoint_integrator_core
// turns stick ticks and setpoint loads into flight setpoint commands
// ----------------------------------------------------------------------------
// a command reaches out_* after its tick is accepted, passing through the
//   queue write and then the back-end output register
// throughput: one input transaction per cycle while out_tready is high,
//   set by the accumulator update in the back end
// a two-entry queue lets the input side keep going during short output stalls
// reset: synchronous active-low rst_n clears setpoints, plan flag, button
//   history and queue; hover_mode resets to 0 and vehicle_id to 1
// ----------------------------------------------------------------------------
module stick_setpoint_integrator_core (
  input  logic                            clk,
  input  logic                            rst_n,
  // input channel
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // in_tdata: axis_roll[7:0], axis_pitch[15:8], axis_yaw[23:16],
  //   axis_climb[31:24], button_up[32], button_down[33], load_lon[65:34],
  //   load_lat[97:66], load_alt[129:98], load_heading[161:130], zero pad
  input  logic [ssi_pkg::IN_DATA_W-1:0]   in_tdata,
  // in_tuser: kind[0]
  input  logic                            in_tuser,
  // result channel
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // out_tdata: altitude_out[31:0], first_value[63:32], second_value[95:64],
  //   heading_out[127:96], vehicle_out[135:128]
  output logic [ssi_pkg::OUT_DATA_W-1:0]  out_tdata,
  // out_tuser: command_code[1:0]
  output logic [1:0]                      out_tuser,
  // configuration write channel
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [ssi_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [ssi_pkg::CFG_DATA_W-1:0]  cfg_data
);

  // configuration registers, always ready for a write
  logic          hover_r, hover_nxt;
  logic [7:0]    vehicle_r, vehicle_nxt;
  ssi_pkg::cfg_t cfg;

  // front to queue
  logic          q_wr;
  ssi_pkg::op_t  q_wdata;
  logic          q_full;

  // queue to back
  logic          q_rd;
  ssi_pkg::op_t  q_rdata;
  logic          q_empty;

  ssi_pkg::res_t res;

  assign cfg_ready = 1'b1;

  always_comb begin
    hover_nxt   = hover_r;
    vehicle_nxt = vehicle_r;
    if (cfg_valid) begin
      case (cfg_index)
        ssi_pkg::CFG_HOVER_MODE: hover_nxt   = cfg_data[0];
        ssi_pkg::CFG_VEHICLE_ID: vehicle_nxt = cfg_data[7:0];
        // writes to unknown indexes are dropped
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hover_r   <= 1'b0;
      vehicle_r <= 8'd1;
    end else begin
      hover_r   <= hover_nxt;
      vehicle_r <= vehicle_nxt;
    end
  end

  assign cfg.hover   = hover_r;
  assign cfg.vehicle = vehicle_r;

  // front: deadband, button edges, per-tick deltas and attitude products
  ssi_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_full    (q_full),
    .q_wr      (q_wr),
    .q_wdata   (q_wdata)
  );

  // classified operations waiting for the integrator
  ssi_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (q_wr),
    .wr_data (q_wdata),
    .full    (q_full),
    .rd_en   (q_rd),
    .rd_data (q_rdata),
    .empty   (q_empty)
  );

  // back: setpoint loads, integration and the output register
  ssi_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .q_empty    (q_empty),
    .q_rdata    (q_rdata),
    .q_rd       (q_rd),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .res        (res)
  );

  assign out_tdata = {res.vehicle, res.heading, res.second, res.first, res.alt};
  assign out_tuser = res.code;

endmodule

/* rtl/core/ssi_checker.sv */
// ----------------------------------------------------------------------------
// ssi_checker
// port-level checks for the stick setpoint integrator
// ----------------------------------------------------------------------------
module ssi_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tready,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [ssi_pkg::OUT_DATA_W-1:0]  out_tdata,
  input logic [1:0]                      out_tuser
);

  // reset leaves no result pending and the queue open
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid && in_tready)
    else $error("result or stall after reset");

  // only the two command codes are ever sent
  a_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tuser == ssi_pkg::CMD_ATT || out_tuser == ssi_pkg::CMD_HOVER))
    else $error("bad command code");

  // attitude values are 1430 times an 8-bit axis
  a_att_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == ssi_pkg::CMD_ATT |->
      $signed(out_tdata[63:32]) <= 32'sd181610 &&
      $signed(out_tdata[63:32]) >= -32'sd183040 &&
      $signed(out_tdata[95:64]) <= 32'sd181610 &&
      $signed(out_tdata[95:64]) >= -32'sd183040)
    else $error("attitude value out of range");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=>
      out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

endmodule

bind stick_setpoint_integrator_core ssi_checker u_ssi_checker (.*);

/* bench/tb.sv */
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the stick setpoint integrator core
// ----------------------------------------------------------------------------
// stick ticks and setpoint loads go in as stream transactions with random
// gaps. A scoreboard class keeps its own copy of the setpoints, the button
// history and the two registers, predicts each command and compares every
// command that comes out, field by field. Registers change only while the
// core is idle. One phase holds the result side off long enough to back up
// the input side.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;

  localparam int          CLK_HALF_NS    = 5;
  localparam int          RESET_CYCLES   = 3;
  localparam int          ITEMS_PER_RUN  = 136;   // random items per setting
  localparam int          NUM_SETTINGS   = 5;
  localparam int          HOLD_CYCLES    = 300;   // long result-side hold-off
  localparam int          SETTLE_CYCLES  = 8;     // room for the queue and the output register
  localparam int          DRAIN_LIMIT    = 5000;
  localparam int          IDLE_PERCENT   = 20;
  localparam longint      RUN_LIMIT_NS   = 2_000_000;

  // predictor constants
  localparam int          DEAD_ZONE      = 10;
  localparam int          ROLL_GAIN      = 1430;
  localparam int          CLIMB_KICK     = 1270;
  localparam int          YAW_GAIN       = 50;
  localparam int          CLIMB_SHR      = 6;
  localparam int          SPEED_SHR      = 3;

  // register index that names no register, writes to it are dropped
  localparam logic [ssi_pkg::CFG_IDX_W-1:0] CFG_UNUSED_IDX = 8'd7;

  // one input transaction, lowest field last
  typedef struct packed {
    logic [5:0]        pad;
    logic [31:0]       heading;
    logic [31:0]       alt;
    logic [31:0]       lat;
    logic [31:0]       lon;
    logic              down;
    logic              up;
    logic signed [7:0] climb;
    logic signed [7:0] yaw;
    logic signed [7:0] pitch;
    logic signed [7:0] roll;
  } stick_item_t;

  // command payload, lowest field last
  typedef struct packed {
    logic [7:0]  vehicle;
    logic [31:0] heading;
    logic [31:0] second;
    logic [31:0] first;
    logic [31:0] alt;
  } cmd_word_t;

  typedef struct packed {
    logic [1:0] code;
    cmd_word_t  word;
  } command_t;

  // --------------------------------------------------------------------------
  // scoreboard: setpoint predictor plus queue of commands still owed
  // --------------------------------------------------------------------------
  class setpoint_scoreboard;
    logic [31:0] lon_sp, lat_sp, alt_sp, head_sp;
    bit          plan_loaded, was_up, was_down;
    bit          hover;
    logic [7:0]  vehicle;
    command_t    owed_q[$];
    int          n_errors, n_checked, n_ticks, n_loads;

    function new();
      lon_sp = '0; lat_sp = '0; alt_sp = '0; head_sp = '0;
      plan_loaded = 0; was_up = 0; was_down = 0;
      hover = 0; vehicle = 8'd1;
      n_errors = 0; n_checked = 0; n_ticks = 0; n_loads = 0;
    endfunction

    function void write_reg(logic [ssi_pkg::CFG_IDX_W-1:0] idx,
                            logic [ssi_pkg::CFG_DATA_W-1:0] val);
      if (idx == ssi_pkg::CFG_HOVER_MODE) hover = val[0];
      else if (idx == ssi_pkg::CFG_VEHICLE_ID) vehicle = val;
    endfunction

    function int trim_deadband(logic signed [7:0] v);
      int x;
      x = int'(v);
      if (x > -DEAD_ZONE && x < DEAD_ZONE) return 0;
      return x;
    endfunction

    function int pending();
      return owed_q.size();
    endfunction

    // note an accepted input transaction and predict its command
    function void note_item(logic kind, stick_item_t it);
      int       roll, pitch, yaw, climb;
      command_t c;
      if (kind == ssi_pkg::KIND_LOAD) begin
        lon_sp = it.lon; lat_sp = it.lat; alt_sp = it.alt; head_sp = it.heading;
        plan_loaded = 1;
        n_loads++;
        return;
      end
      n_ticks++;
      roll  = trim_deadband(it.roll);
      pitch = trim_deadband(it.pitch);
      yaw   = trim_deadband(it.yaw);
      climb = trim_deadband(it.climb);
      // down edge is applied last so it wins over an up edge
      if (it.up && !was_up) climb = -CLIMB_KICK;
      if (it.down && !was_down) climb = CLIMB_KICK;
      was_up = it.up;
      was_down = it.down;
      if (!plan_loaded) return;

      alt_sp  = alt_sp + 32'(climb >>> CLIMB_SHR);
      head_sp = head_sp + 32'(YAW_GAIN * yaw);
      if (hover) begin
        lon_sp = lon_sp + 32'(roll >>> SPEED_SHR);
        lat_sp = lat_sp - 32'(pitch >>> SPEED_SHR);
      end
      c.code         = hover ? ssi_pkg::CMD_HOVER : ssi_pkg::CMD_ATT;
      c.word.alt     = alt_sp;
      c.word.first   = hover ? lat_sp : 32'(ROLL_GAIN * roll);
      c.word.second  = hover ? lon_sp : 32'(ROLL_GAIN * pitch);
      c.word.heading = head_sp;
      c.word.vehicle = vehicle;
      owed_q.push_back(c);
    endfunction

    // compare one accepted command with the oldest one owed
    function void check_command(logic [1:0] code, cmd_word_t got);
      command_t want;
      if (owed_q.size() == 0) begin
        $error("unexpected command: code %0d alt %h", code, got.alt);
        n_errors++;
        return;
      end
      want = owed_q.pop_front();
      n_checked++;
      if (code !== want.code) begin
        $error("command_code: expected %0d, got %0d", want.code, code);
        n_errors++;
      end
      if (got.alt !== want.word.alt) begin
        $error("altitude_out: expected %h, got %h", want.word.alt, got.alt);
        n_errors++;
      end
      if (got.first !== want.word.first) begin
        $error("first_value: expected %h, got %h", want.word.first, got.first);
        n_errors++;
      end
      if (got.second !== want.word.second) begin
        $error("second_value: expected %h, got %h", want.word.second, got.second);
        n_errors++;
      end
      if (got.heading !== want.word.heading) begin
        $error("heading_out: expected %h, got %h", want.word.heading, got.heading);
        n_errors++;
      end
      if (got.vehicle !== want.word.vehicle) begin
        $error("vehicle_out: expected %0d, got %0d", want.word.vehicle, got.vehicle);
        n_errors++;
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // clock, signals, core
  // --------------------------------------------------------------------------
  logic                           clk = 1'b0;
  logic                           rst_n = 1'b0;
  logic                           in_tvalid = 1'b0;
  logic                           in_tready;
  logic [ssi_pkg::IN_DATA_W-1:0]  in_tdata = '0;
  logic                           in_tuser = ssi_pkg::KIND_TICK;
  logic                           out_tvalid;
  logic                           out_tready = 1'b0;
  logic [ssi_pkg::OUT_DATA_W-1:0] out_tdata;
  logic [1:0]                     out_tuser;
  logic                           cfg_valid = 1'b0;
  logic                           cfg_ready;
  logic [ssi_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [ssi_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  setpoint_scoreboard sb = new();

  bit gaps_on  = 1'b1;   // random idling on both sides
  bit hold_req = 1'b0;   // ask the result side for one long hold-off
  int n_in_stalls = 0;   // cycles the core refused an offered transaction
  int n_settings  = 0;

  always begin
    #CLK_HALF_NS clk = 1'b1;
    #CLK_HALF_NS clk = 1'b0;
  end

  stick_setpoint_integrator_core uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // --------------------------------------------------------------------------
  // monitor: every handshake is taken at the rising edge
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_valid && cfg_ready) sb.write_reg(cfg_index, cfg_data);
      if (in_tvalid && in_tready) sb.note_item(in_tuser, stick_item_t'(in_tdata));
      if (in_tvalid && !in_tready) n_in_stalls++;
      if (out_tvalid && out_tready) sb.check_command(out_tuser, cmd_word_t'(out_tdata));
    end
  end

  // --------------------------------------------------------------------------
  // result side: random back-pressure, or one long hold-off on request
  // --------------------------------------------------------------------------
  initial begin : result_sink
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_tready <= 1'b0;
        // counted here so the sender keeps pushing meanwhile
        repeat (HOLD_CYCLES) @(negedge clk);
      end else if (!gaps_on) begin
        out_tready <= 1'b1;
      end else begin
        out_tready <= ($urandom_range(99) >= IDLE_PERCENT);
      end
    end
  end

  // --------------------------------------------------------------------------
  // drivers, all entered and left at a falling edge
  // --------------------------------------------------------------------------
  task automatic send_item(input logic kind, input stick_item_t it);
    if (gaps_on) begin
      while ($urandom_range(99) < IDLE_PERCENT) begin
        in_tvalid <= 1'b0;
        @(negedge clk);
      end
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= it;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_tick(input logic [7:0] roll, input logic [7:0] pitch,
                           input logic [7:0] yaw, input logic [7:0] climb,
                           input logic up, input logic down);
    stick_item_t it;
    it = '0;
    it.roll = roll; it.pitch = pitch; it.yaw = yaw; it.climb = climb;
    it.up = up; it.down = down;
    // the load fields carry noise on ticks, the core must ignore them
    it.lon = $urandom; it.lat = $urandom; it.alt = $urandom; it.heading = $urandom;
    send_item(ssi_pkg::KIND_TICK, it);
  endtask

  task automatic send_load(input logic [31:0] lon, input logic [31:0] lat,
                           input logic [31:0] alt, input logic [31:0] heading);
    stick_item_t it;
    it = '0;
    it.lon = lon; it.lat = lat; it.alt = alt; it.heading = heading;
    // axis and button bits are don't-care on a load
    it.roll = 8'($urandom); it.pitch = 8'($urandom);
    it.yaw = 8'($urandom); it.climb = 8'($urandom);
    it.up = 1'($urandom_range(1)); it.down = 1'($urandom_range(1));
    send_item(ssi_pkg::KIND_LOAD, it);
  endtask

  task automatic write_cfg(input logic [ssi_pkg::CFG_IDX_W-1:0] idx,
                           input logic [ssi_pkg::CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  // stop offering, wait for every owed command, then let loads settle
  task automatic wait_drain();
    int guard;
    guard = 0;
    in_tvalid <= 1'b0;
    while (sb.pending() != 0 && guard < DRAIN_LIMIT) begin
      @(negedge clk);
      guard++;
    end
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // axis value: full range, around the dead zone, extremes or centered
  function automatic logic [7:0] rand_axis();
    case ($urandom_range(9))
      0, 1, 2, 3: return 8'($urandom);
      4, 5, 6:    return 8'($urandom_range(22)) - 8'd11;
      7: begin
        case ($urandom_range(3))
          0: return 8'h7f;
          1: return 8'h80;
          2: return 8'h81;
          default: return 8'h7e;
        endcase
      end
      default:    return 8'h00;
    endcase
  endfunction

  // setpoint for a load: random, near zero, or at the wrap points
  function automatic logic [31:0] rand_setpoint();
    case ($urandom_range(2))
      0: return $urandom;
      1: return 32'($urandom_range(4000)) - 32'd2000;
      default: begin
        case ($urandom_range(3))
          0: return 32'h7fff_ffff;
          1: return 32'h8000_0000;
          2: return 32'hffff_ffff;
          default: return 32'h7fff_ff00;
        endcase
      end
    endcase
  endfunction

  task automatic send_random_item();
    if ($urandom_range(99) < 7)
      send_load(rand_setpoint(), rand_setpoint(), rand_setpoint(), rand_setpoint());
    else
      send_tick(rand_axis(), rand_axis(), rand_axis(), rand_axis(),
                1'($urandom_range(1)), 1'($urandom_range(1)));
  endtask

  // --------------------------------------------------------------------------
  // run limit
  // --------------------------------------------------------------------------
  initial begin : watchdog
    #(RUN_LIMIT_NS);
    $display("run limit reached with %0d commands owed", sb.pending());
    $display("** stick_setpoint_integrator_core: FAILED **");
    $finish;
  end

  // --------------------------------------------------------------------------
  // main sequence
  // --------------------------------------------------------------------------
  initial begin : stimulus
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // attitude mode, reset vehicle id
    n_settings++;
    // ticks before any plan: only button history moves, no command
    send_tick(8'h00, 8'h00, 8'h00, 8'h00, 1'b1, 1'b0);
    send_tick(8'd50, 8'd50, 8'd50, 8'd50, 1'b0, 1'b1);
    send_load(32'h7fff_fff0, 32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff);
    // down still held from before the load, so no climb kick
    send_tick(8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 1'b1);
    // axis extremes, altitude wraps past the top
    send_tick(8'h7f, 8'h80, 8'h7f, 8'h7f, 1'b0, 1'b0);
    send_tick(8'h80, 8'h7f, 8'h80, 8'h80, 1'b0, 1'b0);
    // dead zone edges, 9 drops out and 10 passes
    send_tick(8'd9, -8'sd9, 8'd9, -8'sd9, 1'b0, 1'b0);
    send_tick(8'd10, -8'sd10, 8'd10, -8'sd10, 1'b0, 1'b0);
    // up edge, then held
    send_tick(8'h00, 8'h00, 8'h00, 8'd100, 1'b1, 1'b0);
    send_tick(8'h00, 8'h00, 8'h00, 8'h00, 1'b1, 1'b0);
    // down edge while up stays held
    send_tick(8'h00, 8'h00, 8'h00, 8'h00, 1'b1, 1'b1);
    send_tick(8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0);
    // both edges at once, down wins
    send_tick(8'h00, 8'h00, 8'h00, 8'h00, 1'b1, 1'b1);
    send_tick(-8'sd1, 8'd1, 8'h00, 8'h00, 1'b0, 1'b0);
    wait_drain();

    // hover mode, widest vehicle id
    n_settings++;
    write_cfg(ssi_pkg::CFG_HOVER_MODE, 8'h01);
    write_cfg(ssi_pkg::CFG_VEHICLE_ID, 8'hff);
    send_load(32'h7fff_ffff, 32'h8000_0000, 32'h0000_0000, 32'h0000_0000);
    // lon wraps up, lat wraps down, floor shifts on both signs
    send_tick(8'h7f, 8'h7f, 8'h80, 8'h00, 1'b0, 1'b0);
    send_tick(8'h80, 8'h80, 8'h7f, 8'h00, 1'b0, 1'b0);
    send_tick(-8'sd9, 8'd9, -8'sd10, 8'd11, 1'b0, 1'b0);
    send_tick(-8'sd11, 8'd11, 8'h00, 8'h00, 1'b0, 1'b0);
    send_tick(8'h00, 8'h00, 8'h00, 8'h00, 1'b1, 1'b1);
    // a second load overwrites all four setpoints
    send_load(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
    send_tick(8'h00, 8'h00, 8'h00, 8'h7f, 1'b0, 1'b0);
    wait_drain();

    for (int s = 0; s < NUM_SETTINGS; s++) begin
      n_settings++;
      gaps_on = 1'b1;
      case (s)
        0: begin
          write_cfg(ssi_pkg::CFG_HOVER_MODE, 8'h00);
          write_cfg(ssi_pkg::CFG_VEHICLE_ID, 8'h00);
        end
        1: begin
          write_cfg(ssi_pkg::CFG_HOVER_MODE, 8'h01);
          write_cfg(ssi_pkg::CFG_VEHICLE_ID, 8'hff);
          // long hold-off on the result side while items keep coming
          hold_req = 1'b1;
        end
        2: begin
          write_cfg(ssi_pkg::CFG_VEHICLE_ID, 8'($urandom));
          // long stretch with no idling on either side
          gaps_on = 1'b0;
        end
        3: begin
          // only bit 0 of the hover register counts
          write_cfg(ssi_pkg::CFG_HOVER_MODE, 8'hfe);
          write_cfg(ssi_pkg::CFG_VEHICLE_ID, 8'($urandom));
          // a write to an unused index must change nothing
          write_cfg(CFG_UNUSED_IDX, 8'hff);
        end
        default: begin
          write_cfg(ssi_pkg::CFG_HOVER_MODE, 8'($urandom));
          write_cfg(ssi_pkg::CFG_VEHICLE_ID, 8'($urandom));
        end
      endcase
      for (int i = 0; i < ITEMS_PER_RUN; i++) send_random_item();
      wait_drain();
    end

    if (sb.pending() != 0) begin
      $error("%0d commands never arrived", sb.pending());
      sb.n_errors++;
    end
    $display("run covered %0d ticks and %0d loads over %0d register settings",
             sb.n_ticks, sb.n_loads, n_settings);
    $display("%0d commands compared, input side stalled for %0d cycles",
             sb.n_checked, n_in_stalls);
    if (sb.n_errors == 0) begin
      $display("** stick_setpoint_integrator_core: PASSED **");
    end else begin
      $display("** stick_setpoint_integrator_core: FAILED **");
    end
    $finish;
  end

endmodule

/* stick_setpoint_integrator_core.f */
rtl/core/ssi_pkg.sv
rtl/core/ssi_queue.sv
rtl/core/ssi_front.sv
rtl/core/ssi_back.sv
rtl/core/stick_setpoint_integrator_core.sv
rtl/core/ssi_checker.sv
bench/tb.sv
